// ===== sv/json_string_unescape_assert.svh =====
// assertion macros for the json string unescape block
// expects clk and arst_n in the scope of the module that uses them
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define JSU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define JSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/jsu_pkg.sv =====
// types, codes and helper functions of the json string unescape block
// no dependencies
`default_nettype none

package jsu_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_OPEN = 2'd3
	} kind_t;

	// decoder modes, one-hot
	typedef enum logic [6:0] {
		M_IDLE = 7'b0000001,
		M_BODY = 7'b0000010,
		M_ESC  = 7'b0000100,
		M_HEX1 = 7'b0001000,
		M_HEX2 = 7'b0010000,
		M_HEX3 = 7'b0100000,
		M_HEX4 = 7'b1000000
	} mode_t;

	// command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// characters
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// utf-8 constants
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;
	localparam logic [15:0] UTF_TWO_LIMIT = 16'h0080;
	localparam logic [15:0] UTF_THREE_LIMIT = 16'h0800;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic       ok;
		logic       uni;
		logic [7:0] ch;
	} esc_t;

	// hex digit to value, either case
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// escape letter to character
	function automatic esc_t esc_map(input logic [7:0] c);
		esc_t e;
		e.ok = 1'b1;
		e.uni = 1'b0;
		e.ch = 8'h00;
		case (c)
			8'h22: e.ch = 8'h22;
			8'h5C: e.ch = 8'h5C;
			8'h2F: e.ch = 8'h2F;
			8'h62: e.ch = 8'h08;
			8'h66: e.ch = 8'h0C;
			8'h6E: e.ch = 8'h0A;
			8'h72: e.ch = 8'h0D;
			8'h74: e.ch = 8'h09;
			8'h75: e.uni = 1'b1;
			default: e.ok = 1'b0;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== sv/json_string_unescape.sv =====
// json string body decoder: unescape and utf-8 encode of \u escapes
// depends on jsu_pkg and json_string_unescape_assert.svh
//
// channel  direction  payload     handshake
// req      in         in_item_t   req_valid / req_ready
// rsp      out        out_item_t  rsp_valid / rsp_ready
//
// an item is decoded in the cycle it is accepted; its results (up to three)
// sit in a result buffer and leave one per cycle while rsp_ready is high
// one item per cycle while each gives at most one result and rsp_ready is high;
// an item giving more results is paced by the single-result output port
// req_ready is high when the buffer is empty or its last result leaves
// arst_n clears the mode to idle and empties the result buffer
`default_nettype none

module json_string_unescape
	import jsu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire in_item_t  req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output out_item_t      rsp
);

	mode_t       mode_q, mode_d;
	logic [11:0] hex_q, hex_d;
	out_item_t   res_q [3];
	out_item_t   res_d [3];
	logic [1:0]  cnt_q, cnt_d;
	logic        take, drain, at_end;
	logic [7:0]  c;
	hex_t        hx;
	esc_t        es;
	logic [15:0] code;

	assign drain = rsp_valid && rsp_ready;
	assign req_ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && rsp_ready);
	assign take = req_valid && req_ready;
	assign rsp_valid = (cnt_q != 2'd0);
	assign rsp = res_q[0];

	assign at_end = (req.command == CMD_END);
	assign c = req.data_byte;
	assign hx = hex_digit(c);
	assign es = esc_map(c);
	assign code = {hex_q, hx.val};

	// decode of one item
	always_comb begin
		mode_d = mode_q;
		hex_d = hex_q;
		cnt_d = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res_d[i].out_byte = 8'h00;
			res_d[i].kind = KIND_BYTE;
			res_d[i].last = 1'b0;
		end
		case (mode_q)
			M_BODY: begin
				if (at_end) begin
					res_d[0].kind = KIND_OPEN;
					cnt_d = 2'd1;
					mode_d = M_IDLE;
				end else if (c == CH_QUOTE) begin
					res_d[0].kind = KIND_DONE;
					cnt_d = 2'd1;
					mode_d = M_IDLE;
				end else if (c == CH_BSLASH) begin
					mode_d = M_ESC;
				end else begin
					res_d[0].out_byte = c;
					cnt_d = 2'd1;
				end
			end
			M_ESC: begin
				if (at_end) begin
					res_d[0].kind = KIND_OPEN;
					cnt_d = 2'd1;
					mode_d = M_IDLE;
				end else if (!es.ok) begin
					res_d[0].kind = KIND_BAD;
					cnt_d = 2'd1;
					mode_d = M_IDLE;
				end else if (es.uni) begin
					hex_d = 12'd0;
					mode_d = M_HEX1;
				end else begin
					res_d[0].out_byte = es.ch;
					cnt_d = 2'd1;
					mode_d = M_BODY;
				end
			end
			M_HEX1, M_HEX2, M_HEX3, M_HEX4: begin
				if (at_end) begin
					res_d[0].kind = KIND_OPEN;
					cnt_d = 2'd1;
					mode_d = M_IDLE;
				end else if (!hx.ok) begin
					res_d[0].kind = KIND_BAD;
					cnt_d = 2'd1;
					mode_d = M_IDLE;
				end else if (mode_q != M_HEX4) begin
					hex_d = {hex_q[7:0], hx.val};
					case (mode_q)
						M_HEX1:  mode_d = M_HEX2;
						M_HEX2:  mode_d = M_HEX3;
						default: mode_d = M_HEX4;
					endcase
				end else begin
					// utf-8 encode of the 16-bit code point
					if (code < UTF_TWO_LIMIT) begin
						res_d[0].out_byte = code[7:0];
						cnt_d = 2'd1;
					end else if (code < UTF_THREE_LIMIT) begin
						res_d[0].out_byte = UTF_LEAD2 | {3'd0, code[10:6]};
						res_d[1].out_byte = UTF_CONT | {2'd0, code[5:0]};
						cnt_d = 2'd2;
					end else begin
						res_d[0].out_byte = UTF_LEAD3 | {4'd0, code[15:12]};
						res_d[1].out_byte = UTF_CONT | {2'd0, code[11:6]};
						res_d[2].out_byte = UTF_CONT | {2'd0, code[5:0]};
						cnt_d = 2'd3;
					end
					hex_d = 12'd0;
					mode_d = M_BODY;
				end
			end
			default: begin
				// idle: wait for the opening quote, report bad for anything else
				mode_d = M_IDLE;
				if (!at_end && c == CH_QUOTE) begin
					mode_d = M_BODY;
				end else begin
					res_d[0].kind = KIND_BAD;
					cnt_d = 2'd1;
				end
			end
		endcase
		// mark the final result of the item
		for (int i = 0; i < 3; i++) begin
			res_d[i].last = (cnt_d == 2'(i + 1));
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			hex_q <= 12'd0;
		end else if (take) begin
			mode_q <= mode_d;
			hex_q <= hex_d;
		end
	end

	// result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (take) begin
			cnt_q <= cnt_d;
		end else if (drain) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result buffer payload, shifts down as results leave
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= res_d[i];
			end
		end else if (drain) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	`include "json_string_unescape_assert.svh"

	`JSU_ASSERT_NOW(a_mode_onehot, 1'b1, $onehot(mode_q))
	`JSU_ASSERT_NOW(a_ready_drain, req_ready && cnt_q != 2'd0, cnt_q == 2'd1 && rsp_ready)
	`JSU_ASSERT_NOW(a_status_last, rsp_valid && rsp.kind != KIND_BYTE, rsp.last)
	`JSU_ASSERT_NOW(a_single_last, rsp_valid && cnt_q == 2'd1, rsp.last)
	`JSU_ASSERT_NEXT(a_escape_silent, take && mode_q == M_BODY && !at_end && c == CH_BSLASH,
		mode_q == M_ESC)

endmodule

`default_nettype wire
